>>> design/crc_dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_dfr_pkg
// shared constants, status codes, result type and crc-16 byte updates for the
// sync-delimited frame deframer
// ----------------------------------------------------------------------------
package crc_dfr_pkg;

  // content buffer limit and derived counter width
  localparam int MaxContent = 2048;
  localparam int CntW       = $clog2(MaxContent + 1);

  // frame layout
  localparam int FrameLimit = 2048;
  localparam int HdrBytes   = 6;
  localparam int Overhead   = 8;
  localparam int LenW       = 16;
  localparam int TotW       = LenW + 1;
  localparam int OffW       = ((CntW > LenW) ? CntW : LenW) + 1;

  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  // configuration register indexes
  localparam int          AddrW        = 4;
  localparam logic [1:0] RegSyncFirst  = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegCrcMsb     = 2'd2;

  // item kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  // end of frame status codes
  localparam logic [2:0] StGood       = 3'd0;
  localparam logic [2:0] StEmpty      = 3'd1;
  localparam logic [2:0] StCrc        = 3'd2;
  localparam logic [2:0] StId         = 3'd3;
  localparam logic [2:0] StShort      = 3'd4;
  localparam logic [2:0] StIncomplete = 3'd5;
  localparam logic [2:0] StOversize   = 3'd6;
  localparam logic [2:0] StOverflow   = 3'd7;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [31:0] frame_node_id;
    logic [2:0]  frame_status;
    logic [15:0] payload_length;
    logic [31:0] good_frames;
    logic [31:0] error_frames;
  } res_t;

  // reflected ccitt, poly 0x8408, one byte
  function automatic logic [15:0] crc_refl_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  // msb-first ccitt, poly 0x1021, one byte
  function automatic logic [15:0] crc_msb_byte(input logic [15:0] crc,
                                                input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> design/crc_dfr_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_dfr_in_if / crc_dfr_out_if
// valid/ready channels carrying received bytes in and deframed items out
// ----------------------------------------------------------------------------
interface crc_dfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface crc_dfr_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  payload_byte;
  logic [31:0] frame_node_id;
  logic [2:0]  frame_status;
  logic [15:0] payload_length;
  logic [31:0] good_frames;
  logic [31:0] error_frames;

  modport source (output valid, output out_kind, output payload_byte,
                  output frame_node_id, output frame_status,
                  output payload_length, output good_frames,
                  output error_frames, input ready);
  modport sink   (input valid, input out_kind, input payload_byte,
                  input frame_node_id, input frame_status,
                  input payload_length, input good_frames,
                  input error_frames, output ready);
endinterface

>>> design/crc_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_frame_deframer
// byte-serial deframer for sync-delimited, crc-16 checked frames: hunts the
// two sync bytes, collects content up to cr lf, forwards payload bytes and
// reports a status item on overflow and at each non-empty frame tail
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        op, rx_byte
//  out_o    out  valid/ready        out_kind, payload_byte, frame_node_id,
//                                   frame_status, payload_length,
//                                   good_frames, error_frames
//  apb      in   psel/penable       paddr, pwdata, prdata (pready tied high)
//
//  one item per cycle unless stalled: each byte is parsed, the crc updated
//  in the cycle it is accepted, the result registered at the accepting
//  edge into a two-entry output buffer and offered on out_o from its head
//  in ready depends only on the buffer's second entry, so a stalled output
//  never blocks a byte combinationally; a full buffer holds input off
//  reset clears parser, bound id, counters and configuration registers
// ----------------------------------------------------------------------------
module crc_frame_deframer import crc_dfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  crc_dfr_in_if.sink          in_i,
  crc_dfr_out_if.source       out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // hunt phase codes
  localparam logic [1:0] PhHunt1 = 2'd0;
  localparam logic [1:0] PhHunt2 = 2'd1;
  localparam logic [1:0] PhBody  = 2'd2;

  // configuration
  logic [7:0] sync_first_q, sync_second_q;
  logic       crc_msb_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // parser state
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            saw_cr_q, saw_cr_d;
  logic [31:0]     id_q, id_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     crc_rx_q, crc_rx_d;
  logic [31:0]     bound_q, bound_d;
  logic [31:0]     good_q, good_d;
  logic [31:0]     err_q, err_d;

  // datapath helpers
  logic            accept;
  logic [7:0]      b;
  logic [15:0]     crc_upd;
  logic [CntW-1:0] clen;
  logic [TotW-1:0] total;
  logic [OffW-1:0] off;
  logic [OffW-1:0] tail_off;
  logic            has_res;
  res_t            res;

  // output buffer: head entry drives the port, second entry absorbs a stall
  res_t            head_q, skid_q;
  logic            head_vld_q, skid_vld_q;
  logic            pop;

  // --------------------------------------------------------------------------
  // apb register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      RegSyncFirst:  prdata = {24'h0, sync_first_q};
      RegSyncSecond: prdata = {24'h0, sync_second_q};
      RegCrcMsb:     prdata = {31'h0, crc_msb_q};
      default:       prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'h00;
      sync_second_q <= 8'h00;
      crc_msb_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegSyncFirst:  sync_first_q  <= pwdata[7:0];
        RegSyncSecond: sync_second_q <= pwdata[7:0];
        RegCrcMsb:     crc_msb_q     <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // parser
  // --------------------------------------------------------------------------
  assign in_i.ready = ~skid_vld_q;
  assign accept     = in_i.valid & ~skid_vld_q;
  assign b          = in_i.rx_byte;

  // crc of the running value with this byte, in the configured bit order
  assign crc_upd = crc_msb_q ? crc_msb_byte(crc_q, b) : crc_refl_byte(crc_q, b);

  // content length excluding the cr of the tail
  assign clen  = cnt_q - CntW'(1);
  // whole frame as declared: header, payload, crc
  assign total = TotW'(HdrBytes) + TotW'(len_q) + TotW'(2);
  // position past the header and past the payload
  assign off      = OffW'(cnt_q) - OffW'(HdrBytes);
  assign tail_off = off - OffW'(len_q);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    saw_cr_d = saw_cr_q;
    id_d     = id_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_rx_d = crc_rx_q;
    bound_d  = bound_q;
    good_d   = good_q;
    err_d    = err_q;
    has_res  = 1'b0;
    res.out_kind       = KindPayload;
    res.payload_byte   = 8'h00;
    res.frame_node_id  = id_q;
    res.frame_status   = StGood;
    res.payload_length = len_q;
    res.good_frames    = good_q;
    res.error_frames   = err_q;

    if (accept) begin
      if (in_i.op) begin
        // flush on connect or disconnect, counters and bound id kept
        phase_d  = PhHunt1;
        cnt_d    = '0;
        saw_cr_d = 1'b0;
        id_d     = '0;
        len_d    = '0;
        crc_d    = '0;
        crc_rx_d = '0;
      end else begin
        case (phase_q)
          PhHunt1: begin
            if (b == sync_first_q) phase_d = PhHunt2;
          end
          PhHunt2: begin
            if (b == sync_second_q) begin
              phase_d  = PhBody;
              cnt_d    = '0;
              saw_cr_d = 1'b0;
              id_d     = '0;
              len_d    = '0;
              crc_d    = '0;
              crc_rx_d = '0;
            end else if (b == sync_first_q) begin
              // a failed second byte may itself open a new frame
              phase_d = PhHunt2;
            end else begin
              phase_d = PhHunt1;
            end
          end
          PhBody: begin
            if (saw_cr_q && (b == ByteLf)) begin
              // tail reached: judge the frame
              phase_d  = PhHunt1;
              cnt_d    = '0;
              saw_cr_d = 1'b0;
              id_d     = '0;
              len_d    = '0;
              crc_d    = '0;
              crc_rx_d = '0;
              if (clen != '0) begin
                has_res          = 1'b1;
                res.out_kind     = KindEnd;
                if (clen < CntW'(Overhead)) begin
                  res.frame_status = StShort;
                  err_d            = (&err_q) ? err_q : err_q + 32'd1;
                end else if (TotW'(clen) < total) begin
                  res.frame_status = StIncomplete;
                  err_d            = (&err_q) ? err_q : err_q + 32'd1;
                end else if (total > TotW'(FrameLimit)) begin
                  res.frame_status = StOversize;
                  err_d            = (&err_q) ? err_q : err_q + 32'd1;
                end else if (crc_q != crc_rx_q) begin
                  res.frame_status = StCrc;
                  err_d            = (&err_q) ? err_q : err_q + 32'd1;
                end else if ((bound_q != 32'h0) && (id_q != bound_q)) begin
                  // foreign node, not counted
                  res.frame_status = StId;
                end else begin
                  // first good frame with a nonzero id binds the node id
                  bound_d          = id_q;
                  good_d           = (&good_q) ? good_q : good_q + 32'd1;
                  res.frame_status = (len_q == 16'h0) ? StEmpty : StGood;
                end
                res.good_frames  = good_d;
                res.error_frames = err_d;
              end
            end else if (cnt_q >= CntW'(MaxContent)) begin
              // content buffer full: drop the byte and hunt again
              has_res          = 1'b1;
              res.out_kind     = KindEnd;
              res.frame_status = StOverflow;
              phase_d          = PhHunt1;
              cnt_d            = '0;
              saw_cr_d         = 1'b0;
              id_d             = '0;
              len_d            = '0;
              crc_d            = '0;
              crc_rx_d         = '0;
            end else begin
              cnt_d    = cnt_q + CntW'(1);
              saw_cr_d = (b == ByteCr);
              if (cnt_q < CntW'(4)) begin
                // node id, big-endian
                id_d  = {id_q[23:0], b};
                crc_d = crc_upd;
              end else if (cnt_q < CntW'(HdrBytes)) begin
                // payload length, big-endian
                len_d = {len_q[7:0], b};
                crc_d = crc_upd;
              end else if (off < OffW'(len_q)) begin
                // payload byte, forwarded at once
                crc_d            = crc_upd;
                has_res          = 1'b1;
                res.payload_byte = b;
              end else if (tail_off < OffW'(2)) begin
                // received crc, big-endian; later bytes are ignored
                crc_rx_d = {crc_rx_q[7:0], b};
              end
            end
          end
          default: phase_d = PhHunt1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt1;
      cnt_q    <= '0;
      saw_cr_q <= 1'b0;
      id_q     <= '0;
      len_q    <= '0;
      crc_q    <= '0;
      crc_rx_q <= '0;
      bound_q  <= '0;
      good_q   <= '0;
      err_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      saw_cr_q <= saw_cr_d;
      id_q     <= id_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_rx_q <= crc_rx_d;
      bound_q  <= bound_d;
      good_q   <= good_d;
      err_q    <= err_d;
    end
  end

  // --------------------------------------------------------------------------
  // output buffer
  // --------------------------------------------------------------------------
  assign pop = head_vld_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        // full: only a pop can happen
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (has_res) begin
        if (!head_vld_q || pop) begin
          head_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (pop) begin
        head_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) head_q <= skid_q;
    end else if (has_res) begin
      if (!head_vld_q || pop) begin
        head_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid          = head_vld_q;
  assign out_o.out_kind       = head_q.out_kind;
  assign out_o.payload_byte   = head_q.payload_byte;
  assign out_o.frame_node_id  = head_q.frame_node_id;
  assign out_o.frame_status   = head_q.frame_status;
  assign out_o.payload_length = head_q.payload_length;
  assign out_o.good_frames    = head_q.good_frames;
  assign out_o.error_frames   = head_q.error_frames;

endmodule
